// File: src/qtp_pkg.sv
package qtp_pkg;

	// fixed field widths
	localparam int POS_W  = 24;
	localparam int RATE_W = 32;
	localparam int CFG_W  = 20;
	// quotient bits produced by each divider pipe (Q32 fraction / 32-bit rate)
	localparam int QUO_W  = 32;

	// register reset value, ms
	localparam int DUR_RESET = 1000;

	// unit scaling: ms to s for velocity, ms^2 to s^2 for acceleration
	localparam int VEL_SCALE = 1000;
	localparam int ACC_SCALE = 1000000;

	// sideband carried through the tau divider and the power stages
	typedef struct packed {
		logic [POS_W-1:0] q0;
		logic [POS_W-1:0] spec_pos;  // start or target position at the ends
		logic             special;   // t at or beyond an end of the trajectory
		logic             dneg;      // sign of target - start
		logic [POS_W-1:0] dmag;      // magnitude of target - start
	} trk_t;

	// sideband carried through the velocity divider
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             special;
		logic             neg;
		logic             ovf;
	} vel_side_t;

	// sideband carried through the acceleration divider
	typedef struct packed {
		logic neg;
		logic ovf;
	} acc_side_t;

endpackage

// File: src/qtp_div_pipe.sv
module qtp_div_pipe
	import qtp_pkg::*;
#(
	parameter int DEN_W  = 20,
	parameter int SIDE_W = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [DEN_W-1:0]  in_rem,
	input  logic [QUO_W-1:0]  in_num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [QUO_W-1:0]  out_quo,
	output logic [SIDE_W-1:0] out_side
);

	// one restoring step per stage; in_rem must be below den.
	// nq shifts numerator bits out at the top and quotient bits in at the bottom.
	logic              vld_s  [QUO_W+1];
	logic [DEN_W-1:0]  rem_s  [QUO_W];
	logic [QUO_W-1:0]  nq_s   [QUO_W+1];
	logic [SIDE_W-1:0] side_s [QUO_W+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = in_rem;
	assign nq_s[0]   = in_num;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [DEN_W:0] cat;
		logic [DEN_W:0] diff;
		logic           take;

		// trial subtract of the divisor
		assign cat  = {rem_s[k], nq_s[k][QUO_W-1]};
		assign diff = cat - {1'b0, den};
		assign take = cat >= {1'b0, den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[k+1]   <= {nq_s[k][QUO_W-2:0], take};
				side_s[k+1] <= side_s[k];
			end
		end

		// the final remainder is not needed
		if (k < QUO_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= take ? diff[DEN_W-1:0] : cat[DEN_W-1:0];
				end
			end
		end
	end

	assign out_valid = vld_s[QUO_W];
	assign out_quo   = nq_s[QUO_W];
	assign out_side  = side_s[QUO_W];

endmodule

// File: src/quintic_trajectory_point_top.sv
// Minimum-jerk quintic trajectory sampler for one joint.
// Input channel (in_valid / in_stall): start_position, target_position and
// elapsed_ms; a transfer happens on a clock edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall): position, velocity, acceleration; one
// result per input item, in order.
// Config channel (cfg_valid / cfg_ready): cfg_data sets the trajectory duration
// in ms; cfg_ready is always high. Write it only while no item is in flight.
// The path from the input transfer to out_valid is the input capture register,
// a 32-stage divider for tau, four multiply stages for the powers, polynomial,
// clamp, product, scaling and divider set-up stages, a 32-stage divider pair for
// the rate outputs, and the output register.
// Throughput: one item per cycle while in_stall is low.
// Reset clears all valid bits and loads a duration of 1000 ms.
// When the receiver stalls, a result waits in the output register and one more
// lands in a skid register; with the skid register full, in_stall goes high and
// the whole pipeline holds until the receiver takes the waiting result.
module quintic_trajectory_point_top
	import qtp_pkg::*;
#(
	parameter int TIME_BITS = 20
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// input channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [POS_W-1:0]  start_position,
	input  logic signed [POS_W-1:0]  target_position,
	input  logic        [CFG_W-1:0]  elapsed_ms,
	// output channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [POS_W-1:0]  position,
	output logic signed [RATE_W-1:0] velocity,
	output logic signed [RATE_W-1:0] acceleration,
	// config channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic        [CFG_W-1:0]  cfg_data
);

	localparam int EW    = (TIME_BITS < CFG_W) ? TIME_BITS : CFG_W;
	localparam int DSQ_W = 2 * TIME_BITS;
	localparam int PW    = 42;               // polynomial width, signed
	localparam int NV_W  = 36;               // scaled velocity numerator
	localparam int NA_W  = 48;               // scaled acceleration numerator

	// saturate a magnitude (with overflow flag) to a signed 32-bit value
	function automatic logic [RATE_W-1:0] sat_rate(input logic ovf, input logic neg,
		input logic [RATE_W-1:0] mag);
		logic [RATE_W-1:0] res;
		if (neg) begin
			if (ovf || mag > {1'b1, {(RATE_W-1){1'b0}}}) begin
				res = {1'b1, {(RATE_W-1){1'b0}}};
			end else begin
				res = ~mag + 1'b1;
			end
		end else begin
			if (ovf || mag[RATE_W-1]) begin
				res = {1'b0, {(RATE_W-1){1'b1}}};
			end else begin
				res = mag;
			end
		end
		return res;
	endfunction

	logic en;

	// ---------------- configuration ----------------
	logic [TIME_BITS-1:0] dur_q;
	logic [DSQ_W-1:0]     dsq_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q <= TIME_BITS'(DUR_RESET);
		end else if (cfg_valid && cfg_ready) begin
			dur_q <= TIME_BITS'(cfg_data[EW-1:0]);
		end
	end

	// duration squared, for the acceleration divide
	always_ff @(posedge clk) begin
		dsq_q <= DSQ_W'(dur_q) * DSQ_W'(dur_q);
	end

	// ---------------- s0: input capture ----------------
	logic                 vld_s0;
	logic [POS_W-1:0]     q0_s0;
	logic [POS_W-1:0]     qf_s0;
	logic [TIME_BITS-1:0] t_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q0_s0 <= start_position;
			qf_s0 <= target_position;
			t_s0  <= TIME_BITS'(elapsed_ms[EW-1:0]);
		end
	end

	// end detection, difference and tau divider input
	logic                 at_start;
	logic                 at_end;
	logic [POS_W:0]       d_full;
	logic [POS_W:0]       d_abs;
	logic [TIME_BITS-1:0] tau_rem;
	trk_t                 trk_in;

	always_comb begin
		at_start = (t_s0 == '0);
		at_end   = (t_s0 >= dur_q);
		d_full   = {qf_s0[POS_W-1], qf_s0} - {q0_s0[POS_W-1], q0_s0};
		d_abs    = d_full[POS_W] ? (~d_full + 1'b1) : d_full;
		tau_rem  = (at_start || at_end) ? '0 : t_s0;
		trk_in.q0       = q0_s0;
		trk_in.spec_pos = at_start ? q0_s0 : qf_s0;
		trk_in.special  = at_start || at_end;
		trk_in.dneg     = d_full[POS_W];
		trk_in.dmag     = d_abs[POS_W-1:0];
	end

	// ---------------- tau = t * 2^32 / D ----------------
	logic             tau_vld;
	logic [QUO_W-1:0] tau;
	trk_t             tau_trk;

	qtp_div_pipe #(
		.DEN_W  (TIME_BITS),
		.SIDE_W ($bits(trk_t))
	) u_div_tau (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s0),
		.in_rem    (tau_rem),
		.in_num    ('0),
		.den       (dur_q),
		.in_side   (trk_in),
		.out_valid (tau_vld),
		.out_quo   (tau),
		.out_side  (tau_trk)
	);

	// ---------------- s1..s4: powers of tau ----------------
	logic             vld_s1, vld_s2, vld_s3, vld_s4;
	logic [QUO_W-1:0] tau_s1, tau_s2, tau_s3, tau_s4;
	logic [QUO_W-1:0] t2_s1, t2_s2, t2_s3, t2_s4;
	logic [QUO_W-1:0] t3_s2, t3_s3, t3_s4;
	logic [QUO_W-1:0] t4_s3, t4_s4;
	logic [QUO_W-1:0] t5_s4;
	trk_t             trk_s1, trk_s2, trk_s3, trk_s4;
	logic [2*QUO_W-1:0] sq1, sq2, sq3, sq4;

	assign sq1 = (2*QUO_W)'(tau) * (2*QUO_W)'(tau);
	assign sq2 = (2*QUO_W)'(t2_s1) * (2*QUO_W)'(tau_s1);
	assign sq3 = (2*QUO_W)'(t3_s2) * (2*QUO_W)'(tau_s2);
	assign sq4 = (2*QUO_W)'(t4_s3) * (2*QUO_W)'(tau_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= tau_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tau_s1 <= tau;
			t2_s1  <= sq1[2*QUO_W-1:QUO_W];
			trk_s1 <= tau_trk;

			tau_s2 <= tau_s1;
			t2_s2  <= t2_s1;
			t3_s2  <= sq2[2*QUO_W-1:QUO_W];
			trk_s2 <= trk_s1;

			tau_s3 <= tau_s2;
			t2_s3  <= t2_s2;
			t3_s3  <= t3_s2;
			t4_s3  <= sq3[2*QUO_W-1:QUO_W];
			trk_s3 <= trk_s2;

			tau_s4 <= tau_s3;
			t2_s4  <= t2_s3;
			t3_s4  <= t3_s3;
			t4_s4  <= t4_s3;
			t5_s4  <= sq4[2*QUO_W-1:QUO_W];
			trk_s4 <= trk_s3;
		end
	end

	// ---------------- s5: polynomials ----------------
	logic                 vld_s5;
	logic signed [PW-1:0] p_s5, v_s5, a_s5;
	trk_t                 trk_s5;
	logic signed [PW-1:0] e1, e2, e3, e4, e5;

	assign e1 = PW'(tau_s4);
	assign e2 = PW'(t2_s4);
	assign e3 = PW'(t3_s4);
	assign e4 = PW'(t4_s4);
	assign e5 = PW'(t5_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s5   <= 42'sd6 * e5 - 42'sd15 * e4 + 42'sd10 * e3;
			v_s5   <= 42'sd30 * e4 - 42'sd60 * e3 + 42'sd30 * e2;
			a_s5   <= 42'sd120 * e3 - 42'sd180 * e2 + 42'sd60 * e1;
			trk_s5 <= trk_s4;
		end
	end

	// ---------------- s6: clamp and magnitude ----------------
	logic          vld_s6;
	logic [32:0]   p_s6;
	logic [33:0]   v_s6;
	logic [35:0]   amag_s6;
	logic          aneg_s6;
	trk_t          trk_s6;
	logic [PW-1:0] a_abs;

	assign a_abs = a_s5[PW-1] ? PW'(-a_s5) : PW'(a_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (p_s5 < 0) begin
				p_s6 <= '0;
			end else if (p_s5 > 42'sh1_0000_0000) begin
				p_s6 <= 33'h1_0000_0000;
			end else begin
				p_s6 <= p_s5[32:0];
			end
			v_s6    <= (v_s5 < 0) ? '0 : v_s5[33:0];
			amag_s6 <= a_abs[35:0];
			aneg_s6 <= a_s5[PW-1];
			trk_s6  <= trk_s5;
		end
	end

	// ---------------- s7: scale by the position difference ----------------
	logic        vld_s7;
	logic [56:0] mp_s7;
	logic [57:0] mv_s7;
	logic [59:0] ma_s7;
	logic        aneg_s7;
	trk_t        trk_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mp_s7   <= 57'(trk_s6.dmag) * 57'(p_s6);
			mv_s7   <= 58'(trk_s6.dmag) * 58'(v_s6);
			ma_s7   <= 60'(trk_s6.dmag) * 60'(amag_s6);
			aneg_s7 <= aneg_s6;
			trk_s7  <= trk_s6;
		end
	end

	// ---------------- s8: position and unit scaling ----------------
	logic              vld_s8;
	logic [POS_W-1:0]  pos_s8;
	logic              special_s8;
	logic              vneg_s8;
	logic              aneg_s8;
	logic [NV_W-1:0]   nv_s8;
	logic [NA_W-1:0]   na_s8;
	logic [POS_W-1:0]  pmag;
	logic [59:0]       vsc;
	logic [63:0]       asc;

	assign pmag = mp_s7[32+POS_W-1:32];
	assign vsc  = 60'(mv_s7[57:8]) * 60'(VEL_SCALE);
	assign asc  = 64'(ma_s7[59:16]) * 64'(ACC_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (trk_s7.special) begin
				pos_s8 <= trk_s7.spec_pos;
			end else if (trk_s7.dneg) begin
				pos_s8 <= trk_s7.q0 - pmag;
			end else begin
				pos_s8 <= trk_s7.q0 + pmag;
			end
			special_s8 <= trk_s7.special;
			vneg_s8    <= trk_s7.dneg;
			aneg_s8    <= trk_s7.dneg ^ aneg_s7;
			nv_s8      <= vsc[59:24];
			na_s8      <= asc[63:16];
		end
	end

	// ---------------- s9: overflow check, divider set-up ----------------
	logic                 vld_s9;
	logic [TIME_BITS-1:0] vrem_s9;
	logic [QUO_W-1:0]     vnum_s9;
	logic [DSQ_W-1:0]     arem_s9;
	logic [QUO_W-1:0]     anum_s9;
	vel_side_t            vside_s9;
	acc_side_t            aside_s9;
	logic [TIME_BITS-1:0] nv_hi;
	logic [DSQ_W-1:0]     na_hi;
	logic                 vovf;
	logic                 aovf;

	// quotient of 2^32 or more whenever the high part reaches the divisor
	assign nv_hi = TIME_BITS'(nv_s8[NV_W-1:QUO_W]);
	assign na_hi = DSQ_W'(na_s8[NA_W-1:QUO_W]);
	assign vovf  = nv_hi >= dur_q;
	assign aovf  = na_hi >= dsq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vrem_s9          <= vovf ? '0 : nv_hi;
			vnum_s9          <= nv_s8[QUO_W-1:0];
			arem_s9          <= aovf ? '0 : na_hi;
			anum_s9          <= na_s8[QUO_W-1:0];
			vside_s9.pos     <= pos_s8;
			vside_s9.special <= special_s8;
			vside_s9.neg     <= vneg_s8;
			vside_s9.ovf     <= vovf;
			aside_s9.neg     <= aneg_s8;
			aside_s9.ovf     <= aovf;
		end
	end

	// ---------------- rate dividers: by D and by D^2 ----------------
	logic             vdiv_vld;
	logic             adiv_vld;
	logic [QUO_W-1:0] vquo;
	logic [QUO_W-1:0] aquo;
	vel_side_t        vside;
	acc_side_t        aside;

	qtp_div_pipe #(
		.DEN_W  (TIME_BITS),
		.SIDE_W ($bits(vel_side_t))
	) u_div_vel (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s9),
		.in_rem    (vrem_s9),
		.in_num    (vnum_s9),
		.den       (dur_q),
		.in_side   (vside_s9),
		.out_valid (vdiv_vld),
		.out_quo   (vquo),
		.out_side  (vside)
	);

	qtp_div_pipe #(
		.DEN_W  (DSQ_W),
		.SIDE_W ($bits(acc_side_t))
	) u_div_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s9),
		.in_rem    (arem_s9),
		.in_num    (anum_s9),
		.den       (dsq_q),
		.in_side   (aside_s9),
		.out_valid (adiv_vld),
		.out_quo   (aquo),
		.out_side  (aside)
	);

	// ---------------- result assembly ----------------
	logic              fin_vld;
	logic [POS_W-1:0]  fin_pos;
	logic [RATE_W-1:0] fin_vel;
	logic [RATE_W-1:0] fin_acc;

	always_comb begin
		fin_vld = vdiv_vld && adiv_vld;
		fin_pos = vside.pos;
		if (vside.special) begin
			fin_vel = '0;
			fin_acc = '0;
		end else begin
			fin_vel = sat_rate(vside.ovf, vside.neg, vquo);
			fin_acc = sat_rate(aside.ovf, aside.neg, aquo);
		end
	end

	// ---------------- output register and skid register ----------------
	logic              out_vld_q;
	logic              skid_vld_q;
	logic [POS_W-1:0]  out_pos_q,  skid_pos_q;
	logic [RATE_W-1:0] out_vel_q,  skid_vel_q;
	logic [RATE_W-1:0] out_acc_q,  skid_acc_q;
	logic              out_take;
	logic              load_out;
	logic              load_skid;
	logic              drain_skid;

	assign en         = !skid_vld_q;
	assign out_take   = out_vld_q && !out_stall;
	assign drain_skid = skid_vld_q && out_take;
	assign load_out   = en && fin_vld && (!out_vld_q || out_take);
	assign load_skid  = en && fin_vld && out_vld_q && !out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (drain_skid) begin
				skid_vld_q <= 1'b0;
			end else if (load_skid) begin
				skid_vld_q <= 1'b1;
			end
			if (drain_skid || load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_take) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain_skid) begin
			out_pos_q <= skid_pos_q;
			out_vel_q <= skid_vel_q;
			out_acc_q <= skid_acc_q;
		end else if (load_out) begin
			out_pos_q <= fin_pos;
			out_vel_q <= fin_vel;
			out_acc_q <= fin_acc;
		end
		if (load_skid) begin
			skid_pos_q <= fin_pos;
			skid_vel_q <= fin_vel;
			skid_acc_q <= fin_acc;
		end
	end

	assign in_stall     = skid_vld_q;
	assign out_valid    = out_vld_q;
	assign position     = out_pos_q;
	assign velocity     = out_vel_q;
	assign acceleration = out_acc_q;

endmodule

// File: tb/quintic_trajectory_point_checker.sv
`timescale 1ns / 1ps

module quintic_trajectory_point_checker
	import qtp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic signed [POS_W-1:0]  start_position,
	input  logic signed [POS_W-1:0]  target_position,
	input  logic        [CFG_W-1:0]  elapsed_ms,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic signed [POS_W-1:0]  position,
	input  logic signed [RATE_W-1:0] velocity,
	input  logic signed [RATE_W-1:0] acceleration,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic        [CFG_W-1:0]  cfg_data,
	output int                       fail_count,
	output int                       pending,
	output int                       results_seen
);

	typedef struct {
		logic [POS_W-1:0]  pos;
		logic [RATE_W-1:0] vel;
		logic [RATE_W-1:0] acc;
	} point_t;

	point_t      point_q[$];
	logic [63:0] dur_ms;

	// clamp a magnitude with its sign into 32 bits
	function automatic logic [31:0] clamp_rate(logic [63:0] mag, bit neg);
		if (neg) begin
			if (mag > 64'h8000_0000)
				mag = 64'h8000_0000;
			return 32'(64'd0 - mag);
		end
		if (mag > 64'h7FFF_FFFF)
			mag = 64'h7FFF_FFFF;
		return mag[31:0];
	endfunction

	// minimum-jerk sample at elapsed time t
	function automatic point_t trajectory_point(logic signed [23:0] q0,
			logic signed [23:0] qf, logic [19:0] t_in, logic [63:0] dur);
		point_t r;
		logic [63:0] t, tau, t2, t3, t4, t5, m, mag, dmag;
		longint p, v, a, d, pos;
		t = {44'd0, t_in};
		if (t == 0 || t >= dur) begin
			r.pos = (t == 0) ? q0 : qf;
			r.vel = '0;
			r.acc = '0;
			return r;
		end
		tau = (t << 32) / dur;
		t2 = (tau * tau) >> 32;
		t3 = (t2 * tau) >> 32;
		t4 = (t3 * tau) >> 32;
		t5 = (t4 * tau) >> 32;
		p = 6 * longint'(t5) - 15 * longint'(t4) + 10 * longint'(t3);
		if (p < 0)
			p = 0;
		if (p > (64'sd1 <<< 32))
			p = 64'sd1 <<< 32;
		v = 30 * longint'(t4) - 60 * longint'(t3) + 30 * longint'(t2);
		if (v < 0)
			v = 0;
		a = 120 * longint'(t3) - 180 * longint'(t2) + 60 * longint'(tau);
		d = longint'(qf) - longint'(q0);
		dmag = (d < 0) ? -d : d;
		m = dmag * p;
		mag = m >> 32;
		pos = (d < 0) ? longint'(q0) - longint'(mag) : longint'(q0) + longint'(mag);
		r.pos = pos[23:0];
		m = dmag * v;
		mag = (((m >> 8) * 1000) >> 24) / dur;
		r.vel = clamp_rate(mag, d < 0);
		m = dmag * ((a < 0) ? -a : a);
		mag = ((((m >> 16) * 1000000) >> 16) / dur) / dur;
		r.acc = clamp_rate(mag, ((d < 0) != (a < 0)) && mag != 0);
		return r;
	endfunction

	assign pending = point_q.size();

	always @(posedge clk or negedge arst_n) begin
		point_t want;
		bit     bad;
		if (!arst_n) begin
			dur_ms = DUR_RESET;
			point_q.delete();
			fail_count <= 0;
			results_seen <= 0;
		end else begin
			// register write
			if (cfg_valid && cfg_ready)
				dur_ms = {44'd0, cfg_data};
			// input transfer
			if (in_valid && !in_stall)
				point_q.push_back(trajectory_point(start_position, target_position,
					elapsed_ms, dur_ms));
			// output transfer
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (point_q.size() == 0) begin
					$error("unexpected result pos=%0d", position);
					fail_count <= fail_count + 1;
				end else begin
					want = point_q.pop_front();
					bad = 1'b0;
					if (position !== want.pos) begin
						$error("position exp %0d got %0d", $signed(want.pos), position);
						bad = 1'b1;
					end
					if (velocity !== want.vel) begin
						$error("velocity exp %0d got %0d", $signed(want.vel), velocity);
						bad = 1'b1;
					end
					if (acceleration !== want.acc) begin
						$error("acceleration exp %0d got %0d", $signed(want.acc),
							acceleration);
						bad = 1'b1;
					end
					if (bad)
						fail_count <= fail_count + 1;
				end
			end
		end
	end

endmodule

// File: tb/quintic_trajectory_point_top_test.sv
`timescale 1ns / 1ps

module quintic_trajectory_point_top_test;
	import qtp_pkg::*;

	localparam int LATENCY   = 74;
	localparam int MAX_CYCLE = 400000;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [POS_W-1:0]  start_position;
	logic signed [POS_W-1:0]  target_position;
	logic        [CFG_W-1:0]  elapsed_ms;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [POS_W-1:0]  position;
	logic signed [RATE_W-1:0] velocity;
	logic signed [RATE_W-1:0] acceleration;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic        [CFG_W-1:0]  cfg_data;

	int  fail_count, pending, results_seen;
	int  cycle;
	int  sent;
	bit  hold_off;
	bit  stall_random;
	logic [CFG_W-1:0] dur_now;

	quintic_trajectory_point_top dut (.*);

	quintic_trajectory_point_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > MAX_CYCLE) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else if (hold_off)
			out_stall <= 1'b1;
		else if (!stall_random)
			out_stall <= 1'b0;
		else if ($urandom_range(0, 99) < 25)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(0, 99) < 3) ? 1'b1 : 1'b0;
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// one input transfer, then an optional gap
	task automatic send_point(logic [23:0] q0, logic [23:0] qf, logic [19:0] t,
			bit gaps);
		int g;
		in_valid        <= 1'b1;
		start_position  <= q0;
		target_position <= qf;
		elapsed_ms      <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_duration(logic [CFG_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		dur_now = d;
	endtask

	// random time, weighted toward the inside of the trajectory
	function automatic logic [19:0] pick_time(logic [CFG_W-1:0] d);
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 0;
		if (r < 10)
			return d;
		if (r < 15)
			return 20'($urandom());
		if (d <= 1)
			return 1;
		return 20'($urandom_range(1, 32'(d) - 1));
	endfunction

	function automatic logic [23:0] pick_pos();
		case ($urandom_range(0, 5))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'($urandom_range(0, 2000) - 1000);
			default: return 24'($urandom());
		endcase
	endfunction

	// long hold-off on the receiver, counted in its own process
	task automatic long_hold(int n);
		hold_off = 1;
		repeat (n) @(posedge clk);
		hold_off = 0;
	endtask

	task automatic random_phase(int n, logic [CFG_W-1:0] d);
		write_duration(d);
		for (int i = 0; i < n; i++)
			send_point(pick_pos(), pick_pos(), pick_time(d), 1'b1);
		drain();
	endtask

	initial begin
		logic [CFG_W-1:0] durs[8];
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		start_position  = '0;
		target_position = '0;
		elapsed_ms      = '0;
		cfg_valid       = 1'b0;
		cfg_data        = '0;
		cycle           = 0;
		sent            = 0;
		hold_off        = 0;
		stall_random    = 0;
		dur_now         = CFG_W'(DUR_RESET);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset duration, ends, extremes of the span
		send_point(24'h000000, 24'h100000, 20'd0, 0);
		send_point(24'h000000, 24'h100000, 20'd500, 0);
		send_point(24'h000000, 24'h100000, 20'd1000, 0);
		send_point(24'h000000, 24'h100000, 20'hFFFFF, 0);
		send_point(24'h800000, 24'h7FFFFF, 20'd1, 0);
		send_point(24'h800000, 24'h7FFFFF, 20'd250, 0);
		send_point(24'h7FFFFF, 24'h800000, 20'd999, 0);
		send_point(24'h7FFFFF, 24'h800000, 20'd750, 0);
		send_point(24'h123456, 24'h123456, 20'd400, 0);
		drain();
		// shortest durations, where large rates saturate, then the longest duration
		write_duration(20'd1);
		send_point(24'h800000, 24'h7FFFFF, 20'd0, 0);
		send_point(24'h800000, 24'h7FFFFF, 20'd1, 0);
		drain();
		write_duration(20'd0);
		send_point(24'h000100, 24'h7FFFFF, 20'd0, 0);
		send_point(24'h000100, 24'h7FFFFF, 20'd5, 0);
		drain();
		write_duration(20'd2);
		send_point(24'h800000, 24'h7FFFFF, 20'd1, 0);
		send_point(24'h7FFFFF, 24'h800000, 20'd1, 0);
		drain();
		write_duration(20'hFFFFF);
		send_point(24'h800000, 24'h7FFFFF, 20'd1, 0);
		send_point(24'h800000, 24'h7FFFFF, 20'hFFFFE, 0);
		send_point(24'h7FFFFF, 24'h800000, 20'h7FFFF, 0);
		drain();

		// random phases over several durations, stalls on
		stall_random = 1;
		durs = '{20'd1000, 20'd1, 20'd3, 20'd37, 20'd5000, 20'hFFFFF, 20'd100, 20'd1000};
		foreach (durs[k])
			random_phase(200, durs[k]);

		// pressure: receiver holds off while the sender keeps offering
		write_duration(20'd777);
		fork
			long_hold(400);
			for (int i = 0; i < 150; i++)
				send_point(pick_pos(), pick_pos(), pick_time(20'd777), 1'b0);
		join
		drain();

		// random points with gaps, random duration
		random_phase(100, CFG_W'($urandom_range(1, 20'hFFFFF)));

		$display("Ran %0d items over durations from 0 to 1048575 ms with random stalls,",
			sent);
		$display("gaps and a long receiver hold-off; %0d results checked.", results_seen);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: filelist.f
src/qtp_pkg.sv
src/qtp_div_pipe.sv
src/quintic_trajectory_point_top.sv
tb/quintic_trajectory_point_checker.sv
tb/quintic_trajectory_point_top_test.sv
